@@ design/ibhq_pkg.sv @@
// Shared types and constants of the indexed binary-heap queue.
// Used by the controller, the datapath and the top level; no dependencies.
package ibhq_pkg;

  localparam int HEAP_DEPTH = 1024;
  localparam int KEY_SPACE  = 1024;
  localparam int KEY_W      = 10;
  localparam int POS_W      = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = 11;
  localparam int IDX_W      = POS_W + 2;
  localparam int OP_W       = 2;
  localparam int ADDR_W     = 3;
  localparam int PRIO_W_DEF = 32;
  localparam int DATA_W_DEF = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_UPDATE  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_DUP   = 3'd1,
    ST_EMPTY = 3'd2,
    ST_NOKEY = 3'd3,
    ST_FULL  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_ROOT, S_CLRK, S_LAST, S_UPD,
    S_UP_RD, S_UP_CMP, S_DN_RDL, S_DN_RDR, S_DN_CMP, S_RESP
  } state_t;

  typedef enum logic [2:0] {
    RS_ROOT, RS_LAST, RS_KPPOS, RS_PARENT, RS_LEFT, RS_RIGHT
  } rsel_t;

  typedef struct packed {
    logic    clr_wr;
    logic    ld_in;
    logic    slot_re;
    rsel_t   rsel;
    logic    set_st;
    status_t st;
    logic    ins_begin;
    logic    kp_pos_ld;
    logic    root_take;
    logic    clr_root_key;
    logic    last_take;
    logic    upd_take;
    logic    up_move;
    logic    left_ld;
    logic    dn_step;
    logic    fin_wr;
    logic    out_ld;
  } cmd_t;

  typedef struct packed {
    logic            clr_done;
    logic [OP_W-1:0] op;
    logic            key_ok;
    logic            present;
    logic            fill_zero;
    logic            fill_full;
    logic            pos_zero;
    logic            up_go;
    logic            upd_down;
    logic            dn_stop;
    logic            out_free;
  } stat_t;

endpackage

@@ design/ibhq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ibhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/ibhq_ctrl.sv @@
// Sequencer of the heap queue: clearing pass, checks, sift loops, response.
// Depends on ibhq_pkg; drives the datapath through cmd_t.
module ibhq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ibhq_pkg::stat_t stat,
  output ibhq_pkg::cmd_t  cmd
);

  ibhq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ibhq_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ibhq_pkg::S_CLEAR: if (stat.clr_done) state_nxt = ibhq_pkg::S_IDLE;
      ibhq_pkg::S_IDLE:  if (in_valid) state_nxt = ibhq_pkg::S_CHECK;
      ibhq_pkg::S_CHECK: begin
        state_nxt = ibhq_pkg::S_RESP;
        case (stat.op)
          ibhq_pkg::OP_INSERT: begin
            if (stat.key_ok && !stat.present && !stat.fill_full) begin
              state_nxt = ibhq_pkg::S_UP_RD;
            end
          end
          ibhq_pkg::OP_EXTRACT: if (!stat.fill_zero) state_nxt = ibhq_pkg::S_ROOT;
          ibhq_pkg::OP_UPDATE: begin
            if (!stat.fill_zero && stat.key_ok && stat.present) begin
              state_nxt = ibhq_pkg::S_UPD;
            end
          end
          default: state_nxt = ibhq_pkg::S_RESP;
        endcase
      end
      ibhq_pkg::S_ROOT: state_nxt = ibhq_pkg::S_CLRK;
      ibhq_pkg::S_CLRK: begin
        state_nxt = stat.fill_zero ? ibhq_pkg::S_RESP : ibhq_pkg::S_LAST;
      end
      ibhq_pkg::S_LAST: state_nxt = ibhq_pkg::S_DN_RDL;
      ibhq_pkg::S_UPD: begin
        state_nxt = stat.upd_down ? ibhq_pkg::S_DN_RDL : ibhq_pkg::S_UP_RD;
      end
      ibhq_pkg::S_UP_RD: begin
        state_nxt = stat.pos_zero ? ibhq_pkg::S_RESP : ibhq_pkg::S_UP_CMP;
      end
      ibhq_pkg::S_UP_CMP: begin
        state_nxt = stat.up_go ? ibhq_pkg::S_UP_RD : ibhq_pkg::S_RESP;
      end
      ibhq_pkg::S_DN_RDL: state_nxt = ibhq_pkg::S_DN_RDR;
      ibhq_pkg::S_DN_RDR: state_nxt = ibhq_pkg::S_DN_CMP;
      ibhq_pkg::S_DN_CMP: begin
        state_nxt = stat.dn_stop ? ibhq_pkg::S_RESP : ibhq_pkg::S_DN_RDL;
      end
      ibhq_pkg::S_RESP: if (stat.out_free) state_nxt = ibhq_pkg::S_IDLE;
      default: state_nxt = ibhq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.rsel = ibhq_pkg::RS_ROOT;
    cmd.st   = ibhq_pkg::ST_OK;
    in_stall = 1'b1;
    case (state_r)
      ibhq_pkg::S_CLEAR: cmd.clr_wr = 1'b1;
      ibhq_pkg::S_IDLE: begin
        in_stall   = 1'b0;
        cmd.ld_in  = in_valid;
      end
      ibhq_pkg::S_CHECK: begin
        case (stat.op)
          ibhq_pkg::OP_INSERT: begin
            if (!stat.key_ok) begin
              cmd.set_st = 1'b1;
              cmd.st     = ibhq_pkg::ST_NOKEY;
            end else if (stat.present) begin
              cmd.set_st = 1'b1;
              cmd.st     = ibhq_pkg::ST_DUP;
            end else if (stat.fill_full) begin
              cmd.set_st = 1'b1;
              cmd.st     = ibhq_pkg::ST_FULL;
            end else begin
              cmd.ins_begin = 1'b1;
            end
          end
          ibhq_pkg::OP_EXTRACT: begin
            if (stat.fill_zero) begin
              cmd.set_st = 1'b1;
              cmd.st     = ibhq_pkg::ST_EMPTY;
            end else begin
              cmd.slot_re = 1'b1;
              cmd.rsel    = ibhq_pkg::RS_ROOT;
            end
          end
          ibhq_pkg::OP_UPDATE: begin
            if (stat.fill_zero) begin
              cmd.set_st = 1'b1;
              cmd.st     = ibhq_pkg::ST_EMPTY;
            end else if (!stat.key_ok || !stat.present) begin
              cmd.set_st = 1'b1;
              cmd.st     = ibhq_pkg::ST_NOKEY;
            end else begin
              cmd.kp_pos_ld = 1'b1;
              cmd.slot_re   = 1'b1;
              cmd.rsel      = ibhq_pkg::RS_KPPOS;
            end
          end
          default: ;
        endcase
      end
      ibhq_pkg::S_ROOT: cmd.root_take = 1'b1;
      ibhq_pkg::S_CLRK: begin
        cmd.clr_root_key = 1'b1;
        cmd.slot_re      = !stat.fill_zero;
        cmd.rsel         = ibhq_pkg::RS_LAST;
      end
      ibhq_pkg::S_LAST: cmd.last_take = 1'b1;
      ibhq_pkg::S_UPD:  cmd.upd_take  = 1'b1;
      ibhq_pkg::S_UP_RD: begin
        cmd.fin_wr  = stat.pos_zero;
        cmd.slot_re = !stat.pos_zero;
        cmd.rsel    = ibhq_pkg::RS_PARENT;
      end
      ibhq_pkg::S_UP_CMP: begin
        cmd.up_move = stat.up_go;
        cmd.fin_wr  = !stat.up_go;
      end
      ibhq_pkg::S_DN_RDL: begin
        cmd.slot_re = 1'b1;
        cmd.rsel    = ibhq_pkg::RS_LEFT;
      end
      ibhq_pkg::S_DN_RDR: begin
        cmd.left_ld = 1'b1;
        cmd.slot_re = 1'b1;
        cmd.rsel    = ibhq_pkg::RS_RIGHT;
      end
      ibhq_pkg::S_DN_CMP: begin
        cmd.dn_step = !stat.dn_stop;
        cmd.fin_wr  = stat.dn_stop;
      end
      ibhq_pkg::S_RESP: cmd.out_ld = stat.out_free;
      default: ;
    endcase
  end

endmodule

@@ design/ibhq_dp.sv @@
// Datapath of the heap queue: slot and key-map memories, item registers,
// order compares and result register. Depends on ibhq_pkg and ibhq_ram.
module ibhq_dp #(
  parameter int PRIORITY_WIDTH = ibhq_pkg::PRIO_W_DEF,
  parameter int DATA_WIDTH     = ibhq_pkg::DATA_W_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                max_order,
  input  ibhq_pkg::cmd_t                      cmd,
  output ibhq_pkg::stat_t                     stat,
  input  logic [ibhq_pkg::OP_W-1:0]           in_operation,
  input  logic [ibhq_pkg::KEY_W-1:0]          in_entry_key,
  input  logic signed [PRIORITY_WIDTH-1:0]    in_entry_priority,
  input  logic [DATA_WIDTH-1:0]               in_entry_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_status,
  output logic [ibhq_pkg::KEY_W-1:0]          out_key,
  output logic signed [PRIORITY_WIDTH-1:0]    out_priority,
  output logic [DATA_WIDTH-1:0]               out_data,
  output logic [ibhq_pkg::CNT_W-1:0]          out_entry_count
);

  localparam int KW  = ibhq_pkg::KEY_W;
  localparam int PW  = ibhq_pkg::POS_W;
  localparam int CW  = ibhq_pkg::CNT_W;
  localparam int IW  = ibhq_pkg::IDX_W;
  localparam int SW  = KW + PRIORITY_WIDTH + DATA_WIDTH;
  localparam int MW  = PW + 1;

  function automatic logic earlier(input logic mo,
                                   input logic signed [PRIORITY_WIDTH-1:0] a,
                                   input logic signed [PRIORITY_WIDTH-1:0] b);
    earlier = mo ? (a > b) : (a < b);
  endfunction

  // item and bookkeeping registers
  logic [ibhq_pkg::OP_W-1:0]      op_r;
  logic [KW-1:0]                  key_r;
  logic [KW-1:0]                  ikey_r;
  logic signed [PRIORITY_WIDTH-1:0] prio_r;
  logic [DATA_WIDTH-1:0]          idata_r;
  logic [PW-1:0]                  pos_r;
  logic [CW-1:0]                  fill_r;
  logic [KW-1:0]                  clr_r;
  ibhq_pkg::status_t              status_r;
  logic [KW-1:0]                  rk_r;
  logic signed [PRIORITY_WIDTH-1:0] rp_r;
  logic [DATA_WIDTH-1:0]          rd_r;
  logic [KW-1:0]                  lk_r;
  logic signed [PRIORITY_WIDTH-1:0] lp_r;
  logic [DATA_WIDTH-1:0]          ld_r;
  logic                           ov_r;
  ibhq_pkg::status_t              os_r;
  logic [KW-1:0]                  ok_r;
  logic signed [PRIORITY_WIDTH-1:0] op2_r;
  logic [DATA_WIDTH-1:0]          od_r;
  logic [CW-1:0]                  oc_r;

  // memory ports
  logic          slot_we;
  logic [PW-1:0] slot_waddr, slot_raddr;
  logic [SW-1:0] slot_wdata, slot_rdata;
  logic          kp_we;
  logic [KW-1:0] kp_waddr;
  logic [MW-1:0] kp_wdata, kp_rdata;

  logic [KW-1:0]                    s_key;
  logic signed [PRIORITY_WIDTH-1:0] s_prio;
  logic [DATA_WIDTH-1:0]            s_data;
  logic [PW-1:0]                    kp_pos;

  logic [PW-1:0] par;
  logic [IW-1:0] l_idx, r_idx, fill_x;
  logic          l_ok, r_ok, pick_l, pick_r;
  logic signed [PRIORITY_WIDTH-1:0] f_prio;
  logic [KW-1:0]                    c_key;
  logic signed [PRIORITY_WIDTH-1:0] c_prio;
  logic [DATA_WIDTH-1:0]            c_data;
  logic [PW-1:0]                    c_pos;

  assign {s_key, s_prio, s_data} = slot_rdata;
  assign kp_pos = kp_rdata[PW-1:0];

  assign par    = PW'((pos_r - PW'(1)) >> 1);
  assign l_idx  = {1'b0, pos_r, 1'b1};
  assign r_idx  = {1'b0, pos_r, 1'b0} + IW'(2);
  assign fill_x = IW'(fill_r);
  assign l_ok   = l_idx < fill_x;
  assign r_ok   = r_idx < fill_x;

  // pick the earliest of node, left child, right child; ties keep the earlier pick
  assign pick_l = l_ok && earlier(max_order, lp_r, prio_r);
  assign f_prio = pick_l ? lp_r : prio_r;
  assign pick_r = r_ok && earlier(max_order, s_prio, f_prio);
  assign c_key  = pick_r ? s_key  : lk_r;
  assign c_prio = pick_r ? s_prio : lp_r;
  assign c_data = pick_r ? s_data : ld_r;
  assign c_pos  = pick_r ? r_idx[PW-1:0] : l_idx[PW-1:0];

  always_comb begin
    case (cmd.rsel)
      ibhq_pkg::RS_ROOT:   slot_raddr = '0;
      ibhq_pkg::RS_LAST:   slot_raddr = fill_r[PW-1:0];
      ibhq_pkg::RS_KPPOS:  slot_raddr = kp_pos;
      ibhq_pkg::RS_PARENT: slot_raddr = par;
      ibhq_pkg::RS_LEFT:   slot_raddr = l_idx[PW-1:0];
      ibhq_pkg::RS_RIGHT:  slot_raddr = r_idx[PW-1:0];
      default:             slot_raddr = '0;
    endcase
  end

  always_comb begin
    slot_we    = cmd.up_move || cmd.dn_step || cmd.fin_wr;
    slot_waddr = pos_r;
    slot_wdata = {ikey_r, prio_r, idata_r};
    kp_we      = cmd.clr_wr || cmd.clr_root_key || slot_we;
    kp_waddr   = ikey_r;
    kp_wdata   = {1'b1, pos_r};
    if (cmd.up_move) begin
      slot_wdata = slot_rdata;
      kp_waddr   = s_key;
    end else if (cmd.dn_step) begin
      slot_wdata = {c_key, c_prio, c_data};
      kp_waddr   = c_key;
    end else if (cmd.clr_wr) begin
      kp_waddr = clr_r;
      kp_wdata = '0;
    end else if (cmd.clr_root_key) begin
      kp_waddr = rk_r;
      kp_wdata = '0;
    end
  end

  ibhq_ram #(.WIDTH(SW), .DEPTH(ibhq_pkg::HEAP_DEPTH)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (cmd.slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  ibhq_ram #(.WIDTH(MW), .DEPTH(ibhq_pkg::KEY_SPACE)) u_kp_ram (
    .clk   (clk),
    .we    (kp_we),
    .waddr (kp_waddr),
    .wdata (kp_wdata),
    .re    (cmd.ld_in),
    .raddr (in_entry_key),
    .rdata (kp_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      clr_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_r <= clr_r + KW'(1);
      if (cmd.ins_begin) fill_r <= fill_r + CW'(1);
      else if (cmd.root_take) fill_r <= fill_r - CW'(1);
      if (cmd.out_ld) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      op_r     <= in_operation;
      key_r    <= in_entry_key;
      ikey_r   <= in_entry_key;
      prio_r   <= in_entry_priority;
      idata_r  <= in_entry_data;
      status_r <= ibhq_pkg::ST_OK;
      rk_r     <= '0;
      rp_r     <= '0;
      rd_r     <= '0;
    end
    if (cmd.set_st) status_r <= cmd.st;
    if (cmd.ins_begin) pos_r <= fill_r[PW-1:0];
    if (cmd.kp_pos_ld) pos_r <= kp_pos;
    if (cmd.root_take) begin
      rk_r <= s_key;
      rp_r <= s_prio;
      rd_r <= s_data;
    end
    if (cmd.last_take) begin
      ikey_r  <= s_key;
      prio_r  <= s_prio;
      idata_r <= s_data;
      pos_r   <= '0;
    end
    if (cmd.upd_take) begin
      ikey_r  <= s_key;
      idata_r <= s_data;
    end
    if (cmd.up_move) pos_r <= par;
    if (cmd.dn_step) pos_r <= c_pos;
    if (cmd.left_ld) begin
      lk_r <= s_key;
      lp_r <= s_prio;
      ld_r <= s_data;
    end
    if (cmd.out_ld) begin
      os_r  <= status_r;
      ok_r  <= rk_r;
      op2_r <= rp_r;
      od_r  <= rd_r;
      oc_r  <= fill_r;
    end
  end

  always_comb begin
    stat.clr_done  = clr_r == KW'(ibhq_pkg::KEY_SPACE - 1);
    stat.op        = op_r;
    stat.key_ok    = {1'b0, key_r} < (KW + 1)'(ibhq_pkg::KEY_SPACE);
    stat.present   = kp_rdata[PW];
    stat.fill_zero = fill_r == '0;
    stat.fill_full = fill_r >= CW'(ibhq_pkg::HEAP_DEPTH);
    stat.pos_zero  = pos_r == '0;
    stat.up_go     = earlier(max_order, prio_r, s_prio);
    stat.upd_down  = earlier(max_order, s_prio, prio_r);
    stat.dn_stop   = !pick_l && !pick_r;
    stat.out_free  = !ov_r || !out_stall;
  end

  assign out_valid       = ov_r;
  assign out_status      = os_r;
  assign out_key         = ok_r;
  assign out_priority    = op2_r;
  assign out_data        = od_r;
  assign out_entry_count = oc_r;

endmodule

@@ design/indexed_binary_heap_queue_core.sv @@
// Indexed binary-heap priority queue: insert, extract root and change of
// priority by key, min or max order selected by the max_order register. One
// item is worked at a time; an item that ends in a status check goes from
// the check straight to the response. Insert and an upward update read the
// parent, then compare, at each level; extract and a downward update read the
// left child, then the right child (two reads of the single read port of the
// slot memory), then compare, at each node.
// After reset a clearing pass sweeps the key map with in_stall high;
// configuration writes are taken throughout. A result waits in an output
// register while the next item is accepted.
module indexed_binary_heap_queue_core #(
  parameter int PRIORITY_WIDTH = ibhq_pkg::PRIO_W_DEF,
  parameter int DATA_WIDTH     = ibhq_pkg::DATA_W_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ibhq_pkg::ADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ibhq_pkg::OP_W-1:0]         in_operation,
  input  logic [ibhq_pkg::KEY_W-1:0]        in_entry_key,
  input  logic signed [PRIORITY_WIDTH-1:0]  in_entry_priority,
  input  logic [DATA_WIDTH-1:0]             in_entry_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        out_status,
  output logic [ibhq_pkg::KEY_W-1:0]        out_key,
  output logic signed [PRIORITY_WIDTH-1:0]  out_priority,
  output logic [DATA_WIDTH-1:0]             out_data,
  output logic [ibhq_pkg::CNT_W-1:0]        out_entry_count
);

  logic            max_order_r;
  ibhq_pkg::cmd_t  cmd;
  ibhq_pkg::stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_order_r <= 1'b0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      max_order_r <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {31'd0, max_order_r};

  ibhq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ibhq_dp #(
    .PRIORITY_WIDTH (PRIORITY_WIDTH),
    .DATA_WIDTH     (DATA_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .max_order         (max_order_r),
    .cmd               (cmd),
    .stat              (stat),
    .in_operation      (in_operation),
    .in_entry_key      (in_entry_key),
    .in_entry_priority (in_entry_priority),
    .in_entry_data     (in_entry_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_key           (out_key),
    .out_priority      (out_priority),
    .out_data          (out_data),
    .out_entry_count   (out_entry_count)
  );

`ifndef SYNTH
  // one item at a time: the cycle after a transfer in, the input is stalled
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in work");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= ibhq_pkg::CNT_W'(ibhq_pkg::HEAP_DEPTH)))
    else $error("entry count beyond heap depth");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ibhq_pkg::ST_OK)) |->
      (out_key == '0 && out_priority == '0 && out_data == '0))
    else $error("failed operation returned an entry");
`endif

endmodule

@@ verif/ibhq_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the indexed binary-heap queue: watches the config port and
// both channels, keeps a heap model and compares each result transfer. Needs ibhq_pkg.
module ibhq_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [ibhq_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [ibhq_pkg::OP_W-1:0]       in_operation,
  input  logic [ibhq_pkg::KEY_W-1:0]      in_entry_key,
  input  logic signed [31:0]              in_entry_priority,
  input  logic [31:0]                     in_entry_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [2:0]                      out_status,
  input  logic [ibhq_pkg::KEY_W-1:0]      out_key,
  input  logic signed [31:0]              out_priority,
  input  logic [31:0]                     out_data,
  input  logic [ibhq_pkg::CNT_W-1:0]      out_entry_count,
  output int                              mismatches,
  output int                              outstanding
);

  localparam logic [ibhq_pkg::ADDR_W-1:0] REG_MAX_ORDER = '0;

  typedef struct {
    ibhq_pkg::status_t             st;
    logic [ibhq_pkg::KEY_W-1:0]    key;
    logic signed [31:0]            prio;
    logic [31:0]                   data;
    logic [ibhq_pkg::CNT_W-1:0]    cnt;
  } heap_result_t;

  heap_result_t                pending_results[$];
  logic [ibhq_pkg::KEY_W-1:0]  slot_k[ibhq_pkg::HEAP_DEPTH];
  logic signed [31:0]          slot_p[ibhq_pkg::HEAP_DEPTH];
  logic [31:0]                 slot_d[ibhq_pkg::HEAP_DEPTH];
  int                          key_slot[ibhq_pkg::KEY_SPACE];
  bit                          key_live[ibhq_pkg::KEY_SPACE];
  int                          fill;
  bit                          max_first;

  function automatic bit ahead(logic signed [31:0] a, logic signed [31:0] b);
    return max_first ? (a > b) : (a < b);
  endfunction

  function automatic void place(int pos, logic [ibhq_pkg::KEY_W-1:0] k,
                                logic signed [31:0] p, logic [31:0] d);
    slot_k[pos] = k;
    slot_p[pos] = p;
    slot_d[pos] = d;
    key_slot[k] = pos;
  endfunction

  function automatic void climb(int pos, logic [ibhq_pkg::KEY_W-1:0] k,
                                logic signed [31:0] p, logic [31:0] d);
    int par;
    while (pos > 0) begin
      par = (pos - 1) / 2;
      if (!ahead(p, slot_p[par])) break;
      place(pos, slot_k[par], slot_p[par], slot_d[par]);
      pos = par;
    end
    place(pos, k, p, d);
  endfunction

  function automatic void descend(int pos);
    int l, r, first;
    logic [ibhq_pkg::KEY_W-1:0] k;
    logic signed [31:0] p;
    logic [31:0] d;
    forever begin
      l = 2 * pos + 1;
      r = 2 * pos + 2;
      first = pos;
      if (l < fill && ahead(slot_p[l], slot_p[pos])) first = l;
      if (r < fill && ahead(slot_p[r], slot_p[first])) first = r;
      if (first == pos) break;
      k = slot_k[pos];
      p = slot_p[pos];
      d = slot_d[pos];
      place(pos, slot_k[first], slot_p[first], slot_d[first]);
      place(first, k, p, d);
      pos = first;
    end
  endfunction

  function automatic heap_result_t run_op(logic [ibhq_pkg::OP_W-1:0] op,
                                          logic [ibhq_pkg::KEY_W-1:0] k,
                                          logic signed [31:0] p, logic [31:0] d);
    heap_result_t r;
    int pos;
    r.st = ibhq_pkg::ST_OK;
    r.key = '0;
    r.prio = '0;
    r.data = '0;
    case (op)
      ibhq_pkg::OP_INSERT: begin
        if (key_live[k]) r.st = ibhq_pkg::ST_DUP;
        else if (fill >= ibhq_pkg::HEAP_DEPTH) r.st = ibhq_pkg::ST_FULL;
        else begin
          key_live[k] = 1'b1;
          fill++;
          climb(fill - 1, k, p, d);
        end
      end
      ibhq_pkg::OP_EXTRACT: begin
        if (fill == 0) r.st = ibhq_pkg::ST_EMPTY;
        else begin
          r.key = slot_k[0];
          r.prio = slot_p[0];
          r.data = slot_d[0];
          key_live[slot_k[0]] = 1'b0;
          fill--;
          if (fill > 0) begin
            place(0, slot_k[fill], slot_p[fill], slot_d[fill]);
            descend(0);
          end
        end
      end
      ibhq_pkg::OP_UPDATE: begin
        if (fill == 0) r.st = ibhq_pkg::ST_EMPTY;
        else if (!key_live[k]) r.st = ibhq_pkg::ST_NOKEY;
        else begin
          pos = key_slot[k];
          if (ahead(slot_p[pos], p)) begin
            slot_p[pos] = p;
            descend(pos);
          end else begin
            climb(pos, slot_k[pos], p, slot_d[pos]);
          end
        end
      end
      default: ;
    endcase
    r.cnt = fill[ibhq_pkg::CNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    heap_result_t want;
    if (!rst_n) begin
      pending_results.delete();
      foreach (key_live[i]) key_live[i] = 1'b0;
      fill = 0;
      max_first = 1'b0;
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result transfer with nothing expected: status %0d", $realtime,
                     out_status);
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.st || out_key !== want.key || out_priority !== want.prio ||
              out_data !== want.data || out_entry_count !== want.cnt) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch exp st=%0d key=%0d prio=%0d data=%h cnt=%0d",
                        " / got st=%0d key=%0d prio=%0d data=%h cnt=%0d"},
                       $realtime, want.st, want.key, want.prio, want.data, want.cnt,
                       out_status, out_key, out_priority, out_data, out_entry_count);
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == REG_MAX_ORDER)
        max_first = pwdata[0];
      if (in_valid && !in_stall)
        pending_results.push_back(run_op(in_operation, in_entry_key, in_entry_priority,
                                         in_entry_data));
    end
    outstanding = pending_results.size();
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for indexed_binary_heap_queue_core: drives config writes and
// operations with random gaps and stalls; ibhq_checker does the prediction.
module tb;

  localparam logic [ibhq_pkg::ADDR_W-1:0] REG_MAX_ORDER = '0;
  localparam int SETTLE = 60;
  localparam int IDLE_LIMIT = 6000;
  localparam int DEEP_KEYS = 64;

  logic clk, rst_n;
  logic psel, penable, pwrite, pready;
  logic [ibhq_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [ibhq_pkg::OP_W-1:0] in_operation;
  logic [ibhq_pkg::KEY_W-1:0] in_entry_key, out_key;
  logic signed [31:0] in_entry_priority, out_priority;
  logic [31:0] in_entry_data, out_data;
  logic [2:0] out_status;
  logic [ibhq_pkg::CNT_W-1:0] out_entry_count;
  int mismatches, outstanding;
  int quiet_cycles = 0;
  bit no_gaps;
  bit [1:0] stall_mode = 2'd1;

  indexed_binary_heap_queue_core dut (.*);

  ibhq_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Receiver stall pattern changes mode now and then.
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else begin
      if ($urandom_range(199) == 0) stall_mode <= 2'($urandom_range(3));
      case (stall_mode)
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(3) == 0);
        2'd2: out_stall <= ($urandom_range(9) < 7);
        default: out_stall <= ($urandom_range(49) == 0) ? ~out_stall : out_stall;
      endcase
    end
  end

  task automatic reg_write(logic [ibhq_pkg::ADDR_W-1:0] addr, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send(ibhq_pkg::op_t op, logic [ibhq_pkg::KEY_W-1:0] k,
                      logic signed [31:0] p, logic [31:0] d);
    int g;
    bit taken;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_entry_key <= k;
    in_entry_priority <= p;
    in_entry_data <= d;
    do begin
      #1 taken = !in_stall;
      @(negedge clk);
    end while (!taken);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_priority();
    int r;
    r = $urandom_range(99);
    if (r < 15) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 0;
        default: return -1;
      endcase
    end
    if (r < 50) return $signed($urandom_range(16)) - 8;
    return $signed($urandom);
  endfunction

  function automatic logic [ibhq_pkg::KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 80) return ibhq_pkg::KEY_W'($urandom_range(47));
    if (r < 90) return $urandom_range(1) ? 10'd1023 : 10'd0;
    return ibhq_pkg::KEY_W'($urandom_range(1023));
  endfunction

  task automatic random_run(int n);
    int r;
    ibhq_pkg::op_t op;
    repeat (n) begin
      r = $urandom_range(99);
      op = (r < 45) ? ibhq_pkg::OP_INSERT : (r < 72) ? ibhq_pkg::OP_EXTRACT
                                                     : ibhq_pkg::OP_UPDATE;
      if ($urandom_range(299) == 0) no_gaps = ~no_gaps;
      send(op, pick_key(), pick_priority(), $urandom);
    end
    no_gaps = 1'b0;
    idle_input();
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_operation = ibhq_pkg::OP_INSERT;
    in_entry_key = '0;
    in_entry_priority = '0;
    in_entry_data = '0;
    no_gaps = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed part, smallest priority first.
    reg_write(REG_MAX_ORDER, 32'd0);
    @(negedge clk);
    send(ibhq_pkg::OP_EXTRACT, 10'd0, 0, 0);
    send(ibhq_pkg::OP_UPDATE, 10'd3, 5, 0);
    send(ibhq_pkg::OP_INSERT, 10'd0, 32'sh8000_0000, 32'h0000_0000);
    send(ibhq_pkg::OP_INSERT, 10'd1023, 32'sh7fff_ffff, 32'hffff_ffff);
    send(ibhq_pkg::OP_INSERT, 10'd0, 1, 32'h1234_5678);
    send(ibhq_pkg::OP_UPDATE, 10'd5, 2, 0);
    send(ibhq_pkg::OP_INSERT, 10'd7, 0, 32'haaaa_5555);
    send(ibhq_pkg::OP_INSERT, 10'd8, 0, 32'h5555_aaaa);
    send(ibhq_pkg::OP_INSERT, 10'd9, -1, 32'h0f0f_0f0f);
    send(ibhq_pkg::OP_INSERT, 10'd682, 0, 32'hf0f0_f0f0);
    send(ibhq_pkg::OP_UPDATE, 10'd1023, 32'sh8000_0000, 0);
    send(ibhq_pkg::OP_UPDATE, 10'd0, 32'sh7fff_ffff, 0);
    send(ibhq_pkg::OP_UPDATE, 10'd7, 0, 0);
    send(ibhq_pkg::OP_UPDATE, 10'd341, 0, 0);
    repeat (7) send(ibhq_pkg::OP_EXTRACT, 10'd0, 0, 0);
    send(ibhq_pkg::OP_UPDATE, 10'd7, 0, 0);
    idle_input();

    // Largest first, then smallest first, draining before each order change.
    drain();
    reg_write(REG_MAX_ORDER, 32'd1);
    random_run(150);
    drain();
    reg_write(REG_MAX_ORDER, 32'd0);
    random_run(150);

    // Build a deeper heap in max order, then extract past empty.
    drain();
    reg_write(REG_MAX_ORDER, 32'd1);
    for (int k = 0; k < DEEP_KEYS; k++)
      send(ibhq_pkg::OP_INSERT, k[ibhq_pkg::KEY_W-1:0], pick_priority(), $urandom);
    send(ibhq_pkg::OP_INSERT, 10'd5, 0, 0);
    send(ibhq_pkg::OP_UPDATE, 10'd63, pick_priority(), 0);
    repeat (DEEP_KEYS + 8) send(ibhq_pkg::OP_EXTRACT, 10'd0, 0, 0);
    idle_input();

    drain();
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
